// ===== design/adcrs_pkg.sv =====
`default_nettype none
package adcrs_pkg;

   localparam int unsigned READ_BYTES = 12;
   localparam int unsigned NUM_READINGS = 6;

   // event codes
   localparam logic [2:0] REQ_INIT     = 3'd0;
   localparam logic [2:0] REQ_TIMER    = 3'd1;
   localparam logic [2:0] REQ_ACCEL    = 3'd2;
   localparam logic [2:0] REQ_MAG      = 3'd3;
   localparam logic [2:0] REQ_BOTH     = 3'd4;
   localparam logic [2:0] REQ_SENT     = 3'd5;
   localparam logic [2:0] REQ_BYTE     = 3'd6;

   // action codes
   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_SEND     = 3'd1;
   localparam logic [2:0] ACT_READ     = 3'd2;
   localparam logic [2:0] ACT_TIMER    = 3'd3;
   localparam logic [2:0] ACT_BUSY     = 3'd4;
   localparam logic [2:0] ACT_READING  = 3'd5;
   localparam logic [2:0] ACT_FAIL     = 3'd6;

   // reply modes
   localparam logic [1:0] MODE_ACCEL   = 2'd0;
   localparam logic [1:0] MODE_MAG     = 2'd1;
   localparam logic [1:0] MODE_BOTH    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SETUP_CMD = 2'd0;
   localparam logic [1:0] CSR_SCAN_CMD  = 2'd1;
   localparam logic [1:0] CSR_RETRY     = 2'd2;

   localparam logic [15:0] RETRY_RESET = 16'd500;
   localparam logic [7:0]  ACCEL_MASK  = 8'hFC;
   localparam logic [7:0]  HIGH_MASK   = 8'h03;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] requester;
      logic       bus_busy;
      logic [7:0] data_byte;
      logic       data_last;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  command_byte;
      logic [3:0]  read_length;
      logic [15:0] timer_ticks;
      logic [1:0]  reply_mode;
      logic [7:0]  client;
      logic [2:0]  channel_index;
      logic [9:0]  reading_value;
      logic        last_result;
   } rsp_type;

   // one item's group of results, drained one result a cycle while rsp is not stalled
   typedef struct packed {
      logic [2:0]       action;
      logic [7:0]       command_byte;
      logic [3:0]       read_length;
      logic [15:0]      timer_ticks;
      logic [1:0]       reply_mode;
      logic [7:0]       client;
      logic [2:0]       first;
      logic [2:0]       count;
      logic [5:0][9:0]  readings;
   } burst_type;

endpackage
`default_nettype wire

// ===== design/adc_sensor_readout_sequencer.sv =====
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   adcrs_pkg::req_type_type
// rsp      out        rsp_valid/rsp_stall   adcrs_pkg::rsp_type
// csr      in         csr_wr_en             csr_index, csr_wdata (16 bits)
//
// An event is decoded into the burst register at the edge that accepts it; its
// first result loads the output register when it is empty or not stalled.
// While rsp is not stalled, events with one or no result flow at one per cycle,
// and a completed read emits up to six results, one per cycle from the burst
// register; req stays stalled until its last result moves to the output register.
// A held rsp_stall stalls req once a burst is waiting behind the output register.
// Reset (synchronous) enters the setup state with no result pending.
module adc_sensor_readout_sequencer (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  adcrs_pkg::req_type_type  req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output adcrs_pkg::rsp_type       rsp_data,
   input  wire                      csr_wr_en,
   input  wire  [1:0]               csr_index,
   input  wire  [15:0]              csr_wdata
);

   localparam logic [2:0] ST_SETUP  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_RSETUP = 3'd4;
   localparam logic [2:0] ST_RSCAN  = 3'd5;
   localparam logic [2:0] ST_RREAD  = 3'd6;

   localparam logic [3:0] FULL_COUNT = 4'(adcrs_pkg::READ_BYTES);

   logic [7:0]  setup_cmd_ff, scan_cmd_ff;
   logic [15:0] retry_ff;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  client_ff, client_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  buf_ff [adcrs_pkg::READ_BYTES];
   logic [7:0]  buf_in [adcrs_pkg::READ_BYTES];
   logic [5:0][9:0] rd_ff, rd_in;

   adcrs_pkg::burst_type burst_ff, burst_in;
   logic        burst_valid_ff;
   logic [2:0]  idx_ff;
   logic        has_result;

   adcrs_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;

   logic        go, rsp_load, burst_end;
   logic        do_send, do_read;
   logic [7:0]  send_cmd;
   logic [2:0]  send_go, send_retry;
   logic [3:0]  count_new;
   logic [5:0][9:0] rd_new;
   logic [7:0]  lo;

   assign rsp_load  = burst_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign burst_end = idx_ff == (burst_ff.count - 3'd1);
   assign req_stall = burst_valid_ff && !(rsp_load && burst_end);
   assign go        = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      client_in  = client_ff;
      count_in   = count_ff;
      rd_in      = rd_ff;
      buf_in     = buf_ff;
      burst_in   = '0;
      burst_in.count = 3'd1;
      has_result = 1'b0;
      do_send    = 1'b0;
      do_read    = 1'b0;
      send_cmd   = scan_cmd_ff;
      send_go    = ST_SCAN;
      send_retry = ST_RSCAN;
      count_new  = count_ff;
      rd_new     = rd_ff;
      lo         = '0;

      // buffer write with bypass so the final byte is seen by the unpack below
      if (req_data.req_type == adcrs_pkg::REQ_BYTE) begin
         if (count_ff < FULL_COUNT) begin
            buf_in[count_ff] = req_data.data_byte;
         end
         if (count_ff <= FULL_COUNT) begin
            count_new = count_ff + 4'd1;
         end
      end
      for (int i = 0; i < 6; i++) begin
         lo = buf_in[2 * i + 1];
         if (i >= 3) begin
            lo = lo & adcrs_pkg::ACCEL_MASK;
         end
         rd_new[i] = {2'(buf_in[2 * i] & adcrs_pkg::HIGH_MASK), lo};
      end

      case (req_data.req_type)
         adcrs_pkg::REQ_INIT: begin
            count_in   = '0;
            do_send    = 1'b1;
            send_cmd   = setup_cmd_ff;
            send_go    = ST_SETUP;
            send_retry = ST_RSETUP;
         end
         adcrs_pkg::REQ_TIMER: begin
            case (state_ff)
               ST_RSETUP: begin
                  do_send    = 1'b1;
                  send_cmd   = setup_cmd_ff;
                  send_go    = ST_SETUP;
                  send_retry = ST_RSETUP;
               end
               ST_RSCAN: do_send = 1'b1;
               ST_RREAD: do_read = 1'b1;
               default: ;
            endcase
         end
         adcrs_pkg::REQ_ACCEL, adcrs_pkg::REQ_MAG, adcrs_pkg::REQ_BOTH: begin
            if (state_ff != ST_IDLE) begin
               has_result          = 1'b1;
               burst_in.action     = adcrs_pkg::ACT_BUSY;
               burst_in.reply_mode = 2'(req_data.req_type - adcrs_pkg::REQ_ACCEL);
               burst_in.client     = req_data.requester;
            end else begin
               mode_in   = 2'(req_data.req_type - adcrs_pkg::REQ_ACCEL);
               client_in = req_data.requester;
               do_send   = 1'b1;
            end
         end
         adcrs_pkg::REQ_SENT: begin
            if (state_ff == ST_SETUP) begin
               state_in = ST_IDLE;
            end else if (state_ff == ST_SCAN) begin
               do_read = 1'b1;
            end
         end
         adcrs_pkg::REQ_BYTE: begin
            count_in = count_new;
            if (req_data.data_last) begin
               state_in            = ST_IDLE;
               count_in            = '0;
               has_result          = 1'b1;
               burst_in.reply_mode = mode_ff;
               burst_in.client     = client_ff;
               burst_in.readings   = rd_ff;
               if (count_new != FULL_COUNT) begin
                  if (mode_ff == adcrs_pkg::MODE_BOTH) begin
                     burst_in.action = adcrs_pkg::ACT_READING;
                     burst_in.count  = 3'd6;
                  end else begin
                     burst_in.action = adcrs_pkg::ACT_FAIL;
                  end
               end else begin
                  rd_in             = rd_new;
                  burst_in.readings = rd_new;
                  burst_in.action   = adcrs_pkg::ACT_READING;
                  case (mode_ff)
                     adcrs_pkg::MODE_ACCEL: begin
                        burst_in.first = 3'd3;
                        burst_in.count = 3'd3;
                     end
                     adcrs_pkg::MODE_MAG: burst_in.count = 3'd3;
                     default: burst_in.count = 3'd6;
                  endcase
               end
            end
         end
         default: ;
      endcase

      if (do_send) begin
         has_result = 1'b1;
         if (req_data.bus_busy) begin
            state_in             = send_retry;
            burst_in.action      = adcrs_pkg::ACT_TIMER;
            burst_in.timer_ticks = retry_ff;
         end else begin
            state_in              = send_go;
            burst_in.action       = adcrs_pkg::ACT_SEND;
            burst_in.command_byte = send_cmd;
         end
      end
      if (do_read) begin
         has_result = 1'b1;
         if (req_data.bus_busy) begin
            state_in             = ST_RREAD;
            burst_in.action      = adcrs_pkg::ACT_TIMER;
            burst_in.timer_ticks = retry_ff;
         end else begin
            state_in             = ST_READ;
            count_in             = '0;
            burst_in.action      = adcrs_pkg::ACT_READ;
            burst_in.read_length = FULL_COUNT;
         end
      end
   end

   always_comb begin
      rsp_in               = '0;
      rsp_in.action        = burst_ff.action;
      rsp_in.command_byte  = burst_ff.command_byte;
      rsp_in.read_length   = burst_ff.read_length;
      rsp_in.timer_ticks   = burst_ff.timer_ticks;
      rsp_in.reply_mode    = burst_ff.reply_mode;
      rsp_in.client        = burst_ff.client;
      rsp_in.last_result   = burst_end;
      if (burst_ff.action == adcrs_pkg::ACT_READING) begin
         rsp_in.channel_index = burst_ff.first + idx_ff;
         rsp_in.reading_value = burst_ff.readings[burst_ff.first + idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_cmd_ff   <= '0;
         scan_cmd_ff    <= '0;
         retry_ff       <= adcrs_pkg::RETRY_RESET;
         state_ff       <= ST_SETUP;
         mode_ff        <= '0;
         client_ff      <= '0;
         count_ff       <= '0;
         rd_ff          <= '0;
         burst_valid_ff <= 1'b0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               adcrs_pkg::CSR_SETUP_CMD: setup_cmd_ff <= csr_wdata[7:0];
               adcrs_pkg::CSR_SCAN_CMD:  scan_cmd_ff  <= csr_wdata[7:0];
               adcrs_pkg::CSR_RETRY:     retry_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (go) begin
            state_ff  <= state_in;
            mode_ff   <= mode_in;
            client_ff <= client_in;
            count_ff  <= count_in;
            rd_ff     <= rd_in;
         end
         if (go && has_result) begin
            burst_valid_ff <= 1'b1;
            idx_ff         <= '0;
         end else if (rsp_load && burst_end) begin
            burst_valid_ff <= 1'b0;
         end else if (rsp_load) begin
            idx_ff <= idx_ff + 3'd1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && req_data.req_type == adcrs_pkg::REQ_BYTE) begin
         buf_ff <= buf_in;
      end
      if (go && has_result) begin
         burst_ff <= burst_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== design/adcrs_checker.sv =====
`default_nettype none
module adcrs_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input adcrs_pkg::rsp_type  rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // only a reading burst spans several results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != adcrs_pkg::ACT_READING |-> rsp_data.last_result)
      else $error("non-reading result not last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == adcrs_pkg::ACT_READING
      |-> rsp_data.channel_index < 3'd6 && rsp_data.reply_mode != 2'd3)
      else $error("bad reading result");

   // after a non-final reading transfer the next result continues the burst
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.action == adcrs_pkg::ACT_READING
      && !rsp_data.last_result ##1 rsp_valid
      |-> rsp_data.action == adcrs_pkg::ACT_READING
          && rsp_data.channel_index == $past(rsp_data.channel_index) + 3'd1)
      else $error("reading burst broken");

endmodule

bind adc_sensor_readout_sequencer adcrs_checker u_adcrs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
